// ===== design/fas_pkg.sv =====
// Shared types and constants for the frame animation sequencer.
`default_nettype none
package fas_pkg;

    localparam int MAX_FRAMES_DEF = 64;

    localparam int FRAME_W = 6;
    localparam int COUNT_W = 7;
    localparam int DELTA_W = 24;
    localparam int RATE_W  = 16;
    localparam int FTIME_W = 32;
    localparam int NOTIFY_W = 64;
    localparam int ELAPSED_W = 40;
    localparam int PROD_W = DELTA_W + RATE_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_TIME    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLAY_RATE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_PLAY  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NOTIFY_FRAMES = 3'd5;

    localparam logic [FTIME_W-1:0] FRAME_TIME_RST  = 32'd65536;
    localparam logic [RATE_W-1:0]  PLAY_RATE_RST   = 16'd256;
    localparam logic [COUNT_W-1:0] FRAME_COUNT_RST = 7'd1;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [DELTA_W-1:0] delta_time;
    } t_in;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               finished;
        logic               notify_hit;
    } t_out;

    typedef struct packed {
        logic [FTIME_W-1:0]  frame_time;
        logic [RATE_W-1:0]   play_rate;
        logic [COUNT_W-1:0]  frame_count;
        logic                loop_enable;
        logic                reverse_play;
        logic [NOTIFY_W-1:0] notify_frames;
    } t_cfg;

    // Scaled tick passed from the input stage to the advance stage
    typedef struct packed {
        logic              operation;
        logic [PROD_W-1:0] step;
    } t_scaled;

endpackage
`default_nettype wire

// ===== design/fas_cfg_regs.sv =====
// Configuration register file of the frame animation sequencer.
`default_nettype none
module fas_cfg_regs
    import fas_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_time    <= FRAME_TIME_RST;
            r_cfg.play_rate     <= PLAY_RATE_RST;
            r_cfg.frame_count   <= FRAME_COUNT_RST;
            r_cfg.loop_enable   <= 1'b0;
            r_cfg.reverse_play  <= 1'b0;
            r_cfg.notify_frames <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FRAME_TIME:    r_cfg.frame_time    <= i_cfg_data[FTIME_W-1:0];
                REG_PLAY_RATE:     r_cfg.play_rate     <= i_cfg_data[RATE_W-1:0];
                REG_FRAME_COUNT:   r_cfg.frame_count   <= i_cfg_data[COUNT_W-1:0];
                REG_LOOP_ENABLE:   r_cfg.loop_enable   <= i_cfg_data[0];
                REG_REVERSE_PLAY:  r_cfg.reverse_play  <= i_cfg_data[0];
                REG_NOTIFY_FRAMES: r_cfg.notify_frames <= i_cfg_data[NOTIFY_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ===== design/fas_scale.sv =====
// Input stage: register the beat and scale the time step by the play rate.
`default_nettype none
module fas_scale
    import fas_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire logic              i_in_valid,
    input  wire t_in               i_in,
    input  wire logic [RATE_W-1:0] i_play_rate,
    output logic                   o_valid,
    output t_scaled                o_beat
);

    logic    r_valid;
    t_scaled r_beat;
    t_scaled n_beat;

    always_comb begin
        n_beat.operation = i_in.operation;
        n_beat.step      = PROD_W'(i_in.delta_time) * PROD_W'(i_play_rate);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_in_valid) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule
`default_nettype wire

// ===== design/fas_advance.sv =====
// Advance stage: accumulate elapsed time, step the frame, fire notifies, hold the result.
`default_nettype none
module fas_advance
    import fas_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_take,
    input  wire t_scaled i_beat,
    input  wire t_cfg    i_cfg,
    input  wire logic    i_out_ready,
    output logic         o_out_valid,
    output t_out         o_out
);

    localparam int FIDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    logic [ELAPSED_W-1:0]  r_elapsed, n_elapsed;
    logic [FRAME_W-1:0]    r_frame, n_frame;
    logic [MAX_FRAMES-1:0] r_called, n_called;
    logic                  r_out_valid;
    t_out                  r_out, n_out;

    logic [COUNT_W-1:0]    count;
    logic [FRAME_W-1:0]    last;
    logic [ELAPSED_W:0]    sum;
    logic [ELAPSED_W-1:0]  sat;
    logic [ELAPSED_W-1:0]  threshold;
    logic [COUNT_W-1:0]    next_up;
    logic [MAX_FRAMES-1:0] sel;
    logic [MAX_FRAMES-1:0] called_adv;
    logic                  finished;
    logic                  hit;

    always_comb begin
        // Zero acts as one frame, oversize counts clamp to the frame capacity
        if (i_cfg.frame_count == '0) begin
            count = COUNT_W'(1);
        end else if (i_cfg.frame_count > COUNT_W'(MAX_FRAMES)) begin
            count = COUNT_W'(MAX_FRAMES);
        end else begin
            count = i_cfg.frame_count;
        end
        last = FRAME_W'(count - COUNT_W'(1));

        threshold = {i_cfg.frame_time, 8'h00};
        sum       = {1'b0, r_elapsed} + (ELAPSED_W + 1)'(i_beat.step);
        sat       = sum[ELAPSED_W] ? ELAPSED_MAX : sum[ELAPSED_W-1:0];
        next_up   = COUNT_W'(r_frame) + COUNT_W'(1);

        finished   = 1'b0;
        n_frame    = r_frame;
        n_elapsed  = sat;
        called_adv = r_called;

        if (i_beat.operation == OP_RESTART) begin
            n_elapsed  = '0;
            n_frame    = i_cfg.reverse_play ? last : '0;
            called_adv = '0;
        end else if (sat >= threshold) begin
            n_elapsed = sat - threshold;
            if (i_cfg.reverse_play) begin
                if (r_frame == '0) begin
                    finished = 1'b1;
                    if (i_cfg.loop_enable) begin
                        n_frame    = last;
                        called_adv = '0;
                    end
                end else begin
                    n_frame = r_frame - FRAME_W'(1);
                end
            end else begin
                if (next_up >= count) begin
                    finished = 1'b1;
                    n_frame  = i_cfg.loop_enable ? '0 : last;
                    if (i_cfg.loop_enable) begin
                        called_adv = '0;
                    end
                end else begin
                    n_frame = FRAME_W'(next_up);
                end
            end
        end

        // Frame never exceeds the capacity, so the low bits index the flags
        sel = '0;
        sel[n_frame[FIDX_W-1:0]] = 1'b1;
        hit = (i_beat.operation == OP_TICK)
            && i_cfg.notify_frames[n_frame]
            && !called_adv[n_frame[FIDX_W-1:0]];
        n_called = hit ? (called_adv | sel) : called_adv;

        n_out.frame      = n_frame;
        n_out.finished   = finished;
        n_out.notify_hit = hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed   <= '0;
            r_frame     <= '0;
            r_called    <= '0;
            r_out_valid <= 1'b0;
        end else if (i_take) begin
            r_elapsed   <= n_elapsed;
            r_frame     <= n_frame;
            r_called    <= n_called;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
`default_nettype wire

// ===== design/frame_animation_sequencer_top.sv =====
// Top level of the frame animation sequencer.
// A beat passes the scale register, which holds the 24x16 product, and then
// the advance stage, which updates the accumulator, frame and flags.
// Throughput: one beat per cycle while the result register is empty or drained.
// Reset (synchronous, active low) clears the pipeline, the sequence state and
// loads the register defaults; the block is ready in the first cycle after it.
`default_nettype none
module frame_animation_sequencer_top
    import fas_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in                   i_in,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out                       o_out,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    cfg;
    t_scaled beat;
    logic    s1_valid;
    logic    out_free;
    logic    take;

    assign o_cfg_ready = 1'b1;

    // Advance while the result register is empty or being drained
    assign out_free   = !o_out_valid || i_out_ready;
    assign take       = s1_valid && out_free;
    assign o_in_ready = !s1_valid || out_free;

    fas_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    fas_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (o_in_ready),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .i_play_rate (cfg.play_rate),
        .o_valid     (s1_valid),
        .o_beat      (beat)
    );

    fas_advance #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_advance (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_beat      (beat),
        .i_cfg       (cfg),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with an empty result register");

    a_hit_needs_notify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.notify_hit) |-> cfg.notify_frames[o_out.frame])
        else $error("notify fired on a frame without a notify");

    a_restart_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && beat.operation == OP_RESTART)
            |=> (!o_out.finished && !o_out.notify_hit))
        else $error("restart beat reported finish or notify");

endmodule
`default_nettype wire
